>>> sv/ecf_pkg.sv
// ecf_pkg: shared types, constants and register codes of the effective
// cloud fraction evaluator
// no dependencies
`default_nettype none
package ecf_pkg;

	localparam int MAX_LEVELS_DEF = 64;
	localparam int NUM_BINS_DEF   = 16;

	localparam int CMD_W   = 1;
	localparam int LVL_W   = 8;
	localparam int LBIN_W  = 4;
	localparam int COEF_W  = 20;
	localparam int RH_W    = 18;
	localparam int FRAC_W  = 17;
	localparam int BW_W    = 18;
	localparam int LIM_W   = 18;
	localparam int TOL_W   = 17;
	localparam int ACT_W   = 7;
	localparam int BIN_FW  = 6;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 18;

	// scaling datapath
	localparam int PROD_W = 2 * FRAC_W;
	localparam int NUM_W  = 36;
	localparam int MAG_W  = 35;
	localparam int DEN_W  = 33;
	localparam int QUO_W  = 20;
	localparam int DVD_W  = 56;
	localparam int SCALE_LAT = 26;

	localparam int ITEM_DEPTH = 8;
	localparam int OUT_DEPTH  = 32;

	localparam logic signed [COEF_W-1:0] HALF_Q16 = 20'sd32768;
	localparam logic signed [COEF_W-1:0] SAT_MAX  = 20'sd524287;
	localparam logic signed [COEF_W-1:0] SAT_MIN  = -20'sd524288;

	localparam logic CMD_LOAD    = 1'b0;
	localparam logic CMD_COMPUTE = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_BIN_WIDTH      = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LAST_BIN_LIMIT = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DENOM_TOL      = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LEVELS  = 8'd3;

	typedef struct packed {
		logic [BW_W-1:0]  bin_width;
		logic [LIM_W-1:0] last_bin_limit;
		logic [TOL_W-1:0] denom_tol;
		logic [ACT_W-1:0] active_levels;
	} cfg_t;

	typedef struct packed {
		logic                     is_load;
		logic                     wr_ok;
		logic                     active;
		logic [LVL_W-1:0]         level;
		logic [BIN_FW-1:0]        bin;
		logic signed [COEF_W-1:0] coef_l;
		logic signed [COEF_W-1:0] coef_i;
		logic [FRAC_W-1:0]        cl;
		logic [FRAC_W-1:0]        cf;
	} item_t;

	typedef struct packed {
		logic valid;
		logic compute;
		logic active;
		logic fb;
	} ctl_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] eff_l;
		logic signed [COEF_W-1:0] eff_i;
		logic                     fb;
	} res_t;

endpackage
`default_nettype wire

>>> sv/effective_cloud_fraction_eval.sv
// effective_cloud_fraction_eval: top level, configuration registers and the
// queues between front, back and the result port
// uses ecf_pkg, ecf_front, ecf_fifo, ecf_back
//
// Usage:
//  input channel (in_valid / in_stall): cmd 0 loads a coefficient pair into
//  the (level, load_bin) entry, cmd 1 requests effective fractions. A load
//  gives no result, a compute request gives exactly one, in order.
//  result channel (out_valid / out_stall): eff_liquid, eff_ice, used_fallback.
//  config channel (cfg_valid / cfg_ready, cfg_index, cfg_data): 0 bin width,
//  1 last bin limit, 2 denominator tolerance, 3 active levels; cfg_ready is
//  always high, write only while idle.
// Pipeline: 1+log2(NUM_BINS) front stages (bin division), the request queue,
//  29 back stages (table read, denominator, two 26 stage multiply-divide
//  lanes), then the result queue.
// Throughput: one request per cycle while in_stall is low; the divide
//  lanes are fully pipelined.
// Reset clears the queues, pipelines and registers to their defaults; the
//  coefficient table is not cleared and must be loaded before use.
// When the receiver stalls, results collect in a 32 entry queue; the back
//  end stops issuing once the queue plus results in flight would fill it,
//  then the request queue fills and in_stall rises.
`default_nettype none
module effective_cloud_fraction_eval #(
	parameter int MAX_LEVELS = ecf_pkg::MAX_LEVELS_DEF,
	parameter int NUM_BINS   = ecf_pkg::NUM_BINS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic [ecf_pkg::CMD_W-1:0]            cmd,
	input  wire logic [ecf_pkg::LVL_W-1:0]            level,
	input  wire logic [ecf_pkg::LBIN_W-1:0]           load_bin,
	input  wire logic signed [ecf_pkg::COEF_W-1:0]    coef_liquid,
	input  wire logic signed [ecf_pkg::COEF_W-1:0]    coef_ice,
	input  wire logic [ecf_pkg::RH_W-1:0]             rel_humidity,
	input  wire logic [ecf_pkg::FRAC_W-1:0]           liquid_fraction,
	input  wire logic [ecf_pkg::FRAC_W-1:0]           ice_fraction,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic signed [ecf_pkg::COEF_W-1:0]         eff_liquid,
	output logic signed [ecf_pkg::COEF_W-1:0]         eff_ice,
	output logic                                      used_fallback,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [ecf_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [ecf_pkg::CFG_DATA_W-1:0]       cfg_data
);

	localparam int QD = ecf_pkg::ITEM_DEPTH;
	localparam int OD = ecf_pkg::OUT_DEPTH;

	ecf_pkg::cfg_t  cfg_q;
	logic           f_push;
	ecf_pkg::item_t f_item, q_item;
	logic [$clog2(QD+1)-1:0] q_count;
	logic           q_empty, q_pop;
	logic           b_push;
	ecf_pkg::res_t  b_res, o_res;
	logic [$clog2(OD+1)-1:0] o_count;
	logic           o_empty, o_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bin_width      <= 18'd6554;
			cfg_q.last_bin_limit <= 18'd65536;
			cfg_q.denom_tol      <= 17'd1;
			cfg_q.active_levels  <= 7'd64;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				ecf_pkg::REG_BIN_WIDTH: begin
					cfg_q.bin_width <= cfg_data;
				end
				ecf_pkg::REG_LAST_BIN_LIMIT: begin
					cfg_q.last_bin_limit <= cfg_data;
				end
				ecf_pkg::REG_DENOM_TOL: begin
					cfg_q.denom_tol <= cfg_data[ecf_pkg::TOL_W-1:0];
				end
				ecf_pkg::REG_ACTIVE_LEVELS: begin
					cfg_q.active_levels <= cfg_data[ecf_pkg::ACT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	ecf_front #(
		.MAX_LEVELS(MAX_LEVELS),
		.NUM_BINS  (NUM_BINS),
		.QDEPTH    (QD)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.cmd             (cmd),
		.level           (level),
		.load_bin        (load_bin),
		.coef_liquid     (coef_liquid),
		.coef_ice        (coef_ice),
		.rel_humidity    (rel_humidity),
		.liquid_fraction (liquid_fraction),
		.ice_fraction    (ice_fraction),
		.q_count         (q_count),
		.push            (f_push),
		.push_item       (f_item)
	);

	ecf_fifo #(
		.WIDTH($bits(ecf_pkg::item_t)),
		.DEPTH(QD)
	) u_req_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_push),
		.wdata  (f_item),
		.pop    (q_pop),
		.rdata  (q_item),
		.count  (q_count),
		.empty  (q_empty)
	);

	ecf_back #(
		.MAX_LEVELS(MAX_LEVELS),
		.NUM_BINS  (NUM_BINS),
		.ODEPTH    (OD)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_empty   (q_empty),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.out_count (o_count),
		.push      (b_push),
		.push_res  (b_res)
	);

	ecf_fifo #(
		.WIDTH($bits(ecf_pkg::res_t)),
		.DEPTH(OD)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (b_push),
		.wdata  (b_res),
		.pop    (o_pop),
		.rdata  (o_res),
		.count  (o_count),
		.empty  (o_empty)
	);

	assign out_valid     = !o_empty;
	assign o_pop         = out_valid && !out_stall;
	assign eff_liquid    = o_res.eff_l;
	assign eff_ice       = o_res.eff_i;
	assign used_fallback = o_res.fb;

endmodule
`default_nettype wire

>>> sv/ecf_ram.sv
// ecf_ram: generic single port ram with registered read
// no dependencies
`default_nettype none
module ecf_ram #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule
`default_nettype wire

>>> sv/ecf_fifo.sv
// ecf_fifo: small show-ahead queue in flops
// no dependencies
`default_nettype none
module ecf_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       push,
	input  wire logic [WIDTH-1:0]           wdata,
	input  wire logic                       pop,
	output logic      [WIDTH-1:0]           rdata,
	output logic      [$clog2(DEPTH+1)-1:0] count,
	output logic                            empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wptr_q, rptr_q;
	logic [CW-1:0]    count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	assign rdata = mem_q[rptr_q];
	assign count = count_q;
	assign empty = (count_q == '0);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q < CW'(DEPTH)))
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue read while empty");

endmodule
`default_nettype wire

>>> sv/ecf_front.sv
// ecf_front: accepts items, classifies them and finds the humidity bin
// with a short restoring division pipeline; uses ecf_pkg
`default_nettype none
module ecf_front #(
	parameter int MAX_LEVELS = ecf_pkg::MAX_LEVELS_DEF,
	parameter int NUM_BINS   = ecf_pkg::NUM_BINS_DEF,
	parameter int QDEPTH     = ecf_pkg::ITEM_DEPTH
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire ecf_pkg::cfg_t                       cfg,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic [ecf_pkg::CMD_W-1:0]           cmd,
	input  wire logic [ecf_pkg::LVL_W-1:0]           level,
	input  wire logic [ecf_pkg::LBIN_W-1:0]          load_bin,
	input  wire logic signed [ecf_pkg::COEF_W-1:0]   coef_liquid,
	input  wire logic signed [ecf_pkg::COEF_W-1:0]   coef_ice,
	input  wire logic [ecf_pkg::RH_W-1:0]            rel_humidity,
	input  wire logic [ecf_pkg::FRAC_W-1:0]          liquid_fraction,
	input  wire logic [ecf_pkg::FRAC_W-1:0]          ice_fraction,
	input  wire logic [$clog2(QDEPTH+1)-1:0]         q_count,
	output logic                                     push,
	output ecf_pkg::item_t                           push_item
);

	localparam int BINW = $clog2(NUM_BINS);
	localparam int NST  = BINW + 1;
	localparam int DW   = ecf_pkg::RH_W + BINW;
	localparam int IFW  = $clog2(NST + 1);

	typedef struct packed {
		logic           vld;
		ecf_pkg::item_t item;
		logic           sat;
		logic [DW-1:0]  rem;
		logic [BINW-1:0] quo;
	} fst_t;

	fst_t           stg_s [NST];
	fst_t           nxt [1:BINW];
	fst_t           s0_d;
	logic [IFW-1:0] inflight_q;
	logic           acc;
	logic           lvl_in_tab;
	logic [6:0]     bsel;

	assign in_stall = (int'(q_count) + int'(inflight_q)) >= QDEPTH;
	assign acc = in_valid && !in_stall;

	always_comb begin
		lvl_in_tab = 9'(level) < 9'(MAX_LEVELS);
		s0_d = '0;
		s0_d.vld = acc;
		s0_d.item.is_load = (cmd == ecf_pkg::CMD_LOAD);
		s0_d.item.wr_ok = lvl_in_tab && (7'(load_bin) < 7'(NUM_BINS));
		s0_d.item.active = lvl_in_tab && (9'(level) < 9'(cfg.active_levels));
		s0_d.item.level = level;
		s0_d.item.bin = ecf_pkg::BIN_FW'(load_bin);
		s0_d.item.coef_l = coef_liquid;
		s0_d.item.coef_i = coef_ice;
		s0_d.item.cl = liquid_fraction;
		s0_d.item.cf = ice_fraction;
		// above the last bin limit, zero bin width or a quotient that would not fit the bin field: last bin
		s0_d.sat = (rel_humidity > cfg.last_bin_limit) || (cfg.bin_width == '0)
			|| (DW'(rel_humidity) >= (DW'(cfg.bin_width) << BINW));
		s0_d.rem = DW'(rel_humidity);
		s0_d.quo = '0;
	end

	for (genvar i = 1; i <= BINW; i++) begin : g_div
		localparam int K = BINW - i;
		always_comb begin
			nxt[i] = stg_s[i-1];
			if (stg_s[i-1].rem >= (DW'(cfg.bin_width) << K)) begin
				nxt[i].rem = stg_s[i-1].rem - (DW'(cfg.bin_width) << K);
				nxt[i].quo[K] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NST; i++) begin
				stg_s[i] <= '0;
			end
			inflight_q <= '0;
		end else begin
			stg_s[0] <= s0_d;
			for (int i = 1; i < NST; i++) begin
				stg_s[i] <= nxt[i];
			end
			if (acc && !stg_s[BINW].vld) begin
				inflight_q <= inflight_q + 1'b1;
			end else if (!acc && stg_s[BINW].vld) begin
				inflight_q <= inflight_q - 1'b1;
			end
		end
	end

	always_comb begin
		bsel = (stg_s[BINW].sat || (7'(stg_s[BINW].quo) > 7'(NUM_BINS - 1)))
			? 7'(NUM_BINS - 1) : 7'(stg_s[BINW].quo);
		push_item = stg_s[BINW].item;
		if (!stg_s[BINW].item.is_load) begin
			push_item.bin = bsel[ecf_pkg::BIN_FW-1:0];
		end
	end

	assign push = stg_s[BINW].vld;

	a_bin_range: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !push_item.is_load) |-> (7'(push_item.bin) < 7'(NUM_BINS)))
		else $error("compute request left front with bin outside table");

endmodule
`default_nettype wire

>>> sv/ecf_scale.sv
// ecf_scale: pipelined coef*num/den with round half away from zero and
// saturation; uses ecf_pkg
`default_nettype none
module ecf_scale (
	input  wire logic                               clk,
	input  wire logic signed [ecf_pkg::COEF_W-1:0]  coef,
	input  wire logic signed [ecf_pkg::NUM_W-1:0]   num,
	input  wire logic [ecf_pkg::DEN_W-1:0]          den,
	output logic signed [ecf_pkg::COEF_W-1:0]       res
);

	localparam int CW = ecf_pkg::COEF_W;
	localparam int QW = ecf_pkg::QUO_W;
	localparam int VW = ecf_pkg::DVD_W;
	localparam int DNW = ecf_pkg::DEN_W;

	logic              neg_s1, neg_s2, neg_s3, neg_s4;
	logic [CW-1:0]     mc_s1;
	logic [ecf_pkg::MAG_W-1:0] mn_s1;
	logic [DNW-1:0]    den_s1, den_s2, den_s3, den_s4;
	logic [CW+17:0]    plo_s2;
	logic [CW+16:0]    phi_s2;
	logic [CW+ecf_pkg::MAG_W-1:0] mag_s3;
	logic [VW-1:0]     dvd_s4;

	logic [VW-1:0]     rem_s [QW+1];
	logic [QW-1:0]     quo_s [QW+1];
	logic [DNW-1:0]    den_s [QW+1];
	logic              neg_s [QW+1];
	logic              ovf_s [QW+1];
	logic              sat;

	always_ff @(posedge clk) begin
		neg_s1 <= coef[CW-1] ^ num[ecf_pkg::NUM_W-1];
		mc_s1  <= coef[CW-1] ? CW'(-coef) : CW'(coef);
		mn_s1  <= num[ecf_pkg::NUM_W-1] ? ecf_pkg::MAG_W'(-num)
			: num[ecf_pkg::MAG_W-1:0];
		den_s1 <= den;

		plo_s2 <= mc_s1 * mn_s1[17:0];
		phi_s2 <= mc_s1 * mn_s1[ecf_pkg::MAG_W-1:18];
		neg_s2 <= neg_s1;
		den_s2 <= den_s1;

		mag_s3 <= (CW+ecf_pkg::MAG_W)'(plo_s2) + ((CW+ecf_pkg::MAG_W)'(phi_s2) << 18);
		neg_s3 <= neg_s2;
		den_s3 <= den_s2;

		// add half the divisor for rounding
		dvd_s4 <= VW'(mag_s3) + VW'(den_s3 >> 1);
		neg_s4 <= neg_s3;
		den_s4 <= den_s3;

		rem_s[0] <= dvd_s4;
		quo_s[0] <= '0;
		den_s[0] <= den_s4;
		neg_s[0] <= neg_s4;
		ovf_s[0] <= dvd_s4 >= (VW'(den_s4) << QW);
	end

	for (genvar j = 0; j < QW; j++) begin : g_div
		localparam int K = QW - 1 - j;
		always_ff @(posedge clk) begin
			if (rem_s[j] >= (VW'(den_s[j]) << K)) begin
				rem_s[j+1] <= rem_s[j] - (VW'(den_s[j]) << K);
				quo_s[j+1] <= quo_s[j] | (QW'(1) << K);
			end else begin
				rem_s[j+1] <= rem_s[j];
				quo_s[j+1] <= quo_s[j];
			end
			den_s[j+1] <= den_s[j];
			neg_s[j+1] <= neg_s[j];
			ovf_s[j+1] <= ovf_s[j];
		end
	end

	assign sat = ovf_s[QW] || quo_s[QW][QW-1];

	always_ff @(posedge clk) begin
		if (neg_s[QW]) begin
			res <= sat ? ecf_pkg::SAT_MIN : CW'(-quo_s[QW]);
		end else begin
			res <= sat ? ecf_pkg::SAT_MAX : CW'(quo_s[QW]);
		end
	end

endmodule
`default_nettype wire

>>> sv/ecf_back.sv
// ecf_back: coefficient table, denominator and fallback check, and the two
// scaling lanes; uses ecf_pkg, ecf_ram, ecf_scale
`default_nettype none
module ecf_back #(
	parameter int MAX_LEVELS = ecf_pkg::MAX_LEVELS_DEF,
	parameter int NUM_BINS   = ecf_pkg::NUM_BINS_DEF,
	parameter int ODEPTH     = ecf_pkg::OUT_DEPTH
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire ecf_pkg::cfg_t                 cfg,
	input  wire logic                          q_empty,
	input  wire ecf_pkg::item_t                q_item,
	output logic                               q_pop,
	input  wire logic [$clog2(ODEPTH+1)-1:0]   out_count,
	output logic                               push,
	output ecf_pkg::res_t                      push_res
);

	localparam int DEPTH = MAX_LEVELS * NUM_BINS;
	localparam int ADDRW = $clog2(DEPTH);
	localparam int IFW   = $clog2(ODEPTH + 1);
	localparam int CW    = ecf_pkg::COEF_W;
	localparam int NW    = ecf_pkg::NUM_W;
	localparam int LAT   = ecf_pkg::SCALE_LAT;

	logic                   issue;
	logic [IFW-1:0]         inflight_q;
	logic                   vld_s1, vld_s2;
	ecf_pkg::item_t         item_s1, item_s2;
	logic [ecf_pkg::PROD_W-1:0] p_s2;
	logic                   ram_we;
	logic [ADDRW-1:0]       ram_addr;
	logic [2*CW-1:0]        ram_rdata;
	logic signed [NW-1:0]   den_full, tol_ext, numl, numi;
	logic                   fb;
	ecf_pkg::ctl_t          ctl_s3;
	logic [ecf_pkg::DEN_W-1:0] den_s3;
	logic signed [NW-1:0]   numl_s3, numi_s3;
	logic signed [CW-1:0]   coefl_s3, coefi_s3;
	logic signed [CW-1:0]   effl, effi;
	ecf_pkg::ctl_t          dly_s [LAT];
	ecf_pkg::ctl_t          tail;

	// issue only with room reserved in the result queue
	assign issue = !q_empty && ((int'(out_count) + int'(inflight_q)) < ODEPTH);
	assign q_pop = issue;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			ctl_s3 <= '0;
			for (int i = 0; i < LAT; i++) begin
				dly_s[i] <= '0;
			end
			inflight_q <= '0;
		end else begin
			vld_s1 <= issue;
			vld_s2 <= vld_s1;
			ctl_s3.valid   <= vld_s2;
			ctl_s3.compute <= !item_s2.is_load;
			ctl_s3.active  <= item_s2.active;
			ctl_s3.fb      <= fb;
			dly_s[0] <= ctl_s3;
			for (int i = 1; i < LAT; i++) begin
				dly_s[i] <= dly_s[i-1];
			end
			if ((issue && !q_item.is_load) && !push) begin
				inflight_q <= inflight_q + 1'b1;
			end else if (!(issue && !q_item.is_load) && push) begin
				inflight_q <= inflight_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		item_s1 <= q_item;
		item_s2 <= item_s1;
		p_s2    <= item_s1.cl * item_s1.cf;
		den_s3  <= den_full[ecf_pkg::DEN_W-1:0];
		numl_s3 <= numl;
		numi_s3 <= numi;
		coefl_s3 <= ram_rdata[2*CW-1:CW];
		coefi_s3 <= ram_rdata[CW-1:0];
	end

	assign ram_we = vld_s1 && item_s1.is_load && item_s1.wr_ok;
	assign ram_addr = ADDRW'(int'(item_s1.level) * NUM_BINS + int'(item_s1.bin));

	ecf_ram #(
		.WIDTH(2 * CW),
		.DEPTH(DEPTH)
	) u_coef_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata ({item_s1.coef_l, item_s1.coef_i}),
		.rdata (ram_rdata)
	);

	always_comb begin
		den_full = $signed(NW'(37'h1_0000_0000)) - $signed({2'b00, p_s2});
		tol_ext  = $signed({3'b000, cfg.denom_tol, 16'h0000});
		fb       = den_full <= tol_ext;
		numl     = $signed({3'b000, item_s2.cl, 16'h0000}) - $signed({2'b00, p_s2});
		numi     = $signed({3'b000, item_s2.cf, 16'h0000}) - $signed({2'b00, p_s2});
	end

	ecf_scale u_scale_liquid (
		.clk  (clk),
		.coef (coefl_s3),
		.num  (numl_s3),
		.den  (den_s3),
		.res  (effl)
	);

	ecf_scale u_scale_ice (
		.clk  (clk),
		.coef (coefi_s3),
		.num  (numi_s3),
		.den  (den_s3),
		.res  (effi)
	);

	assign tail = dly_s[LAT-1];
	assign push = tail.valid && tail.compute;

	always_comb begin
		if (!tail.active) begin
			push_res = '0;
		end else if (tail.fb) begin
			push_res.eff_l = ecf_pkg::HALF_Q16;
			push_res.eff_i = ecf_pkg::HALF_Q16;
			push_res.fb    = 1'b1;
		end else begin
			push_res.eff_l = effl;
			push_res.eff_i = effi;
			push_res.fb    = 1'b0;
		end
	end

	a_credit: assert property (@(posedge clk) disable iff (!arst_n)
		(int'(out_count) + int'(inflight_q)) <= ODEPTH)
		else $error("result queue credit exceeded");

endmodule
`default_nettype wire

>>> tb/effective_cloud_fraction_eval_tb.sv
// effective_cloud_fraction_eval_tb: coefficient load and effective fraction checks
// against an in-bench bit-accurate predictor, with random idling on both channels
// depends on ecf_pkg and effective_cloud_fraction_eval
`timescale 1ns / 100ps
`default_nettype none
module effective_cloud_fraction_eval_tb;

	localparam int LEVELS = ecf_pkg::MAX_LEVELS_DEF;
	localparam int BINS = ecf_pkg::NUM_BINS_DEF;
	localparam int FILL_LEVELS = 16;
	localparam int DRAIN_CYCLES = 60;
	localparam int WATCHDOG_LIMIT = 20000;

	localparam int CMW = ecf_pkg::CMD_W;
	localparam int LW = ecf_pkg::LVL_W;
	localparam int LBW = ecf_pkg::LBIN_W;
	localparam int CW = ecf_pkg::COEF_W;
	localparam int RW = ecf_pkg::RH_W;
	localparam int FW = ecf_pkg::FRAC_W;
	localparam int IW = ecf_pkg::CFG_IDX_W;
	localparam int DW = ecf_pkg::CFG_DATA_W;

	localparam logic [IW-1:0] REG_UNUSED = 8'd9;

	typedef struct {
		logic signed [CW-1:0] eff_l;
		logic signed [CW-1:0] eff_i;
		logic fb;
	} frac_result_t;

	class frac_scoreboard;
		logic [ecf_pkg::BW_W-1:0] bin_width;
		logic [ecf_pkg::LIM_W-1:0] last_limit;
		logic [ecf_pkg::TOL_W-1:0] tol;
		logic [ecf_pkg::ACT_W-1:0] act_levels;
		logic signed [CW-1:0] liq_tab [LEVELS*BINS];
		logic signed [CW-1:0] ice_tab [LEVELS*BINS];
		bit written [LEVELS*BINS];
		frac_result_t pending [$];
		int mismatches;
		int results_seen;

		function new();
			bin_width = 18'd6554;
			last_limit = 18'd65536;
			tol = 17'd1;
			act_levels = 7'd64;
			mismatches = 0;
			results_seen = 0;
		endfunction

		function logic signed [CW-1:0] scaled(logic signed [CW-1:0] coef,
				longint num, longint den);
			longint prod;
			longint unsigned mag;
			longint unsigned q;
			longint r;
			prod = longint'(coef) * num;
			mag = (prod < 0) ? longint'(-prod) : longint'(prod);
			q = (mag + den / 2) / den;
			if (q > 524288) q = 524288;
			r = (prod < 0) ? -longint'(q) : longint'(q);
			if (r > 524287) r = 524287;
			if (r < -524288) r = -524288;
			return r[CW-1:0];
		endfunction

		// returns the bin a compute request will read
		function int pick_bin(logic [RW-1:0] rh);
			int b;
			if (rh > last_limit || bin_width == 0) return BINS - 1;
			b = rh / bin_width;
			return (b > BINS - 1) ? BINS - 1 : b;
		endfunction

		// true when every bin of the level has been loaded
		function bit level_ready(int lvl);
			for (int b = 0; b < BINS; b++)
				if (!written[lvl * BINS + b]) return 0;
			return 1;
		endfunction

		function void note_request(logic c, logic [LW-1:0] lvl, logic [LBW-1:0] lb,
				logic signed [CW-1:0] cq, logic signed [CW-1:0] ci,
				logic [RW-1:0] rh, logic [FW-1:0] cl, logic [FW-1:0] cf);
			frac_result_t r;
			longint p;
			longint den;
			int idx;
			if (c == ecf_pkg::CMD_LOAD) begin
				if (lvl < LEVELS && lb < BINS) begin
					idx = lvl * BINS + lb;
					liq_tab[idx] = cq;
					ice_tab[idx] = ci;
					written[idx] = 1;
				end
				return;
			end
			r.eff_l = 0;
			r.eff_i = 0;
			r.fb = 0;
			if (lvl < act_levels && lvl < LEVELS) begin
				p = longint'(cl) * longint'(cf);
				den = (longint'(1) << 32) - p;
				if (den <= (longint'(tol) << 16)) begin
					r.eff_l = ecf_pkg::HALF_Q16;
					r.eff_i = ecf_pkg::HALF_Q16;
					r.fb = 1;
				end else begin
					idx = lvl * BINS + pick_bin(rh);
					r.eff_l = scaled(liq_tab[idx], longint'(cl) * 65536 - p, den);
					r.eff_i = scaled(ice_tab[idx], longint'(cf) * 65536 - p, den);
				end
			end
			pending.push_back(r);
		endfunction

		task check_result(logic signed [CW-1:0] el, logic signed [CW-1:0] ei, logic fb);
			frac_result_t e;
			results_seen++;
			if (pending.size() == 0) begin
				report_mismatch("result with nothing pending", 0, 0);
				return;
			end
			e = pending.pop_front();
			if (el !== e.eff_l) report_mismatch("eff_liquid", el, e.eff_l);
			if (ei !== e.eff_i) report_mismatch("eff_ice", ei, e.eff_i);
			if (fb !== e.fb) report_mismatch("used_fallback", fb, e.fb);
		endtask

		task report_mismatch(string what, longint got, longint want);
			mismatches++;
			if (mismatches <= 40)
				$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		endtask
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [CMW-1:0] cmd = 0;
	logic [LW-1:0] level = 0;
	logic [LBW-1:0] load_bin = 0;
	logic signed [CW-1:0] coef_liquid = 0;
	logic signed [CW-1:0] coef_ice = 0;
	logic [RW-1:0] rel_humidity = 0;
	logic [FW-1:0] liquid_fraction = 0;
	logic [FW-1:0] ice_fraction = 0;
	logic out_valid;
	logic out_stall = 0;
	logic signed [CW-1:0] eff_liquid;
	logic signed [CW-1:0] eff_ice;
	logic used_fallback;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [IW-1:0] cfg_index = 0;
	logic [DW-1:0] cfg_data = 0;

	frac_scoreboard fsb = new();
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int idle_cycles = 0;
	int requests_sent = 0;

	always #2 clk = ~clk;

	effective_cloud_fraction_eval dut (.*);

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			fsb.check_result(eff_liquid, eff_ice, used_fallback);
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && !((in_valid && !in_stall) || (out_valid && !out_stall)
				|| (cfg_valid && cfg_ready)))
			idle_cycles++;
		else
			idle_cycles = 0;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
			$display("effective_cloud_fraction_eval verification failed");
			$finish;
		end
	end

	task automatic write_reg(logic [IW-1:0] idx, logic [DW-1:0] val);
		@(posedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		case (idx)
			ecf_pkg::REG_BIN_WIDTH: fsb.bin_width = val;
			ecf_pkg::REG_LAST_BIN_LIMIT: fsb.last_limit = val;
			ecf_pkg::REG_DENOM_TOL: fsb.tol = val[ecf_pkg::TOL_W-1:0];
			ecf_pkg::REG_ACTIVE_LEVELS: fsb.act_levels = val[ecf_pkg::ACT_W-1:0];
			default: ;
		endcase
	endtask

	// one request; valid stays high between back-to-back requests
	task automatic send_request(logic c, logic [LW-1:0] lvl, logic [LBW-1:0] lb,
			logic signed [CW-1:0] cq, logic signed [CW-1:0] ci,
			logic [RW-1:0] rh, logic [FW-1:0] cl, logic [FW-1:0] cf);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		cmd <= c;
		level <= lvl;
		load_bin <= lb;
		coef_liquid <= cq;
		coef_ice <= ci;
		rel_humidity <= rh;
		liquid_fraction <= cl;
		ice_fraction <= cf;
		do @(posedge clk); while (in_stall);
		fsb.note_request(c, lvl, lb, cq, ci, rh, cl, cf);
		requests_sent++;
	endtask

	task automatic wait_idle();
		in_valid <= 0;
		@(posedge clk);
		while (fsb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [FW-1:0] rand_frac();
		case ($urandom_range(5))
			0: return 17'd65536;
			1: return 17'd0;
			2: return FW'($urandom_range(131071));
			3: return FW'(65536 - $urandom_range(64));
			default: return FW'($urandom_range(65536));
		endcase
	endfunction

	// compute request on a level whose bins are all loaded, or on a level outside the table
	task automatic rand_compute();
		logic [LW-1:0] lvl;
		logic [RW-1:0] rh;
		case ($urandom_range(9))
			0: lvl = LW'($urandom_range(255));
			1: lvl = LW'(LEVELS - 1);
			default: lvl = LW'($urandom_range(FILL_LEVELS - 1));
		endcase
		if (lvl < LEVELS && !fsb.level_ready(lvl)) lvl = 8'd200;
		rh = ($urandom_range(3) == 0) ? RW'($urandom_range(262143))
			: RW'($urandom_range(70000));
		send_request(ecf_pkg::CMD_COMPUTE, lvl, LBW'($urandom), CW'($urandom),
			CW'($urandom), rh, rand_frac(), rand_frac());
	endtask

	task automatic rand_load();
		send_request(ecf_pkg::CMD_LOAD, ($urandom_range(7) == 0) ? LW'($urandom_range(255))
			: LW'($urandom_range(LEVELS - 1)), LBW'($urandom), CW'($urandom),
			CW'($urandom), RW'($urandom), FW'($urandom), FW'($urandom));
	endtask

	task automatic random_phase(int n);
		for (int k = 0; k < n; k++)
			if ($urandom_range(3) == 0) rand_load(); else rand_compute();
		wait_idle();
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);

		// fill the low levels and the top level so no compute reads an unwritten entry
		for (int l = 0; l < LEVELS; l++)
			if (l < FILL_LEVELS || l == LEVELS - 1)
				for (int b = 0; b < BINS; b++)
					send_request(ecf_pkg::CMD_LOAD, LW'(l), LBW'(b), CW'($urandom),
						CW'($urandom), 0, 0, 0);
		wait_idle();

		// directed: extremes, ignored loads, fallback, inactive levels
		send_request(ecf_pkg::CMD_LOAD, 0, 0, 20'sh7FFFF, 20'sh80000, 0, 0, 0);
		send_request(ecf_pkg::CMD_LOAD, 63, 15, 20'sh80000, 20'sh7FFFF, 0, 0, 0);
		send_request(ecf_pkg::CMD_LOAD, 255, 15, 20'sh12345, 20'sh54321, 0, 0, 0);
		send_request(ecf_pkg::CMD_COMPUTE, 0, 0, 0, 0, 0, 17'd0, 17'd0);
		send_request(ecf_pkg::CMD_COMPUTE, 0, 15, 0, 0, 0, 17'd65536, 17'd0);
		send_request(ecf_pkg::CMD_COMPUTE, 0, 0, 0, 0, 0, 17'd65536, 17'd65536);
		send_request(ecf_pkg::CMD_COMPUTE, 0, 0, 0, 0, 0, 17'd65535, 17'd65535);
		send_request(ecf_pkg::CMD_COMPUTE, 63, 0, 0, 0, 18'h3FFFF, 17'd131071, 17'd1);
		send_request(ecf_pkg::CMD_COMPUTE, 63, 0, 0, 0, 18'h3FFFF, 17'd1, 17'd131071);
		send_request(ecf_pkg::CMD_COMPUTE, 63, 0, 0, 0, 18'd65536, 17'd40000, 17'd30000);
		send_request(ecf_pkg::CMD_COMPUTE, 64, 0, 0, 0, 18'd1000, 17'd1000, 17'd1000);
		send_request(ecf_pkg::CMD_COMPUTE, 255, 0, 0, 0, 18'd1000, 17'd1000, 17'd1000);
		send_request(ecf_pkg::CMD_COMPUTE, 10, 0, 0, 0, 18'd65537, 17'd20000, 17'd50000);
		wait_idle();

		send_idle_pct = 12;
		recv_idle_pct = 47;
		random_phase(160);
		write_reg(ecf_pkg::REG_BIN_WIDTH, 18'd1);
		write_reg(ecf_pkg::REG_LAST_BIN_LIMIT, 18'h3FFFF);
		write_reg(ecf_pkg::REG_DENOM_TOL, 18'd0);
		write_reg(ecf_pkg::REG_ACTIVE_LEVELS, 18'd0);
		write_reg(REG_UNUSED, 18'd5);
		random_phase(50);
		write_reg(ecf_pkg::REG_ACTIVE_LEVELS, 18'd20);
		write_reg(ecf_pkg::REG_BIN_WIDTH, 18'h3FFFF);
		write_reg(ecf_pkg::REG_DENOM_TOL, 18'd65536);
		random_phase(80);

		send_idle_pct = 47;
		recv_idle_pct = 12;
		write_reg(ecf_pkg::REG_DENOM_TOL, 18'd300);
		write_reg(ecf_pkg::REG_LAST_BIN_LIMIT, 18'd0);
		write_reg(ecf_pkg::REG_BIN_WIDTH, 18'd0);
		write_reg(ecf_pkg::REG_ACTIVE_LEVELS, 18'd64);
		random_phase(160);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_reg(ecf_pkg::REG_BIN_WIDTH, 18'd4096);
		write_reg(ecf_pkg::REG_LAST_BIN_LIMIT, 18'd60000);
		write_reg(ecf_pkg::REG_DENOM_TOL, 18'd1);
		write_reg(ecf_pkg::REG_ACTIVE_LEVELS, 18'd127);
		random_phase(160);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d requests and %0d results over several register settings",
			requests_sent, fsb.results_seen);
		if (fsb.mismatches == 0 && fsb.pending.size() == 0) begin
			$display("effective_cloud_fraction_eval verification clean");
		end else begin
			$display("%0d mismatches, %0d results outstanding", fsb.mismatches,
				fsb.pending.size());
			$display("effective_cloud_fraction_eval verification failed");
		end
		$finish;
	end
endmodule
`default_nettype wire

>>> filelist.f
sv/ecf_pkg.sv
sv/ecf_ram.sv
sv/ecf_fifo.sv
sv/ecf_front.sv
sv/ecf_scale.sv
sv/ecf_back.sv
sv/effective_cloud_fraction_eval.sv
tb/effective_cloud_fraction_eval_tb.sv
